// ===== rtl/hafk_pkg.sv =====
`default_nettype none
// ============================================================================
// hafk_pkg: shared definitions for the haptic arm forward kinematics block
// Widths, fixed-point constants, polynomial coefficients, register indexes,
// the pipeline record of the sine/cosine cells and the Q.30 product helpers.
// ============================================================================
package hafk_pkg;

    localparam int ANGLE_W    = 24;
    localparam int TRIG_W     = 32;
    localparam int ROT_W      = 18;
    localparam int POS_W      = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int ORIGIN_W   = 63;
    localparam int NUM_ANGLES = 6;
    localparam int NUM_ROT    = 9;
    localparam int NUM_POS    = 3;
    localparam int MQ_W       = 34;

    // Angle reduction, all Q.28.
    localparam int TWO_PI_W = 31;
    localparam logic [TWO_PI_W-1:0] HALF_PI     = 31'd421657428;
    localparam logic [TWO_PI_W-1:0] EIGHTH_TURN = 31'd210828714;
    localparam logic [TWO_PI_W-1:0] TWO_PI      = 31'd1686629712;
    localparam int PROD_W    = 56;
    localparam int RED_W     = 37;
    localparam int RED_STEPS = 7;
    // Forty-eight full turns make every corrected angle positive.
    localparam logic [RED_W-1:0] RED_BIAS = 37'd80958226176;

    // Polynomial coefficients, Q.30.
    localparam int POLY_CELLS = 5;
    localparam int SIN_CELLS  = 3;
    localparam logic signed [TRIG_W-1:0] SIN_INIT = 32'sd2959;
    localparam logic signed [TRIG_W-1:0] COS_INIT = -32'sd296;
    localparam logic signed [TRIG_W-1:0] SIN_K [SIN_CELLS] =
        '{-32'sd213044, 32'sd8947849, -32'sd178956971};
    localparam logic signed [TRIG_W-1:0] COS_K [POLY_CELLS] =
        '{32'sd26631, -32'sd1491308, 32'sd44739243, -32'sd536870912, 32'sd1073741824};

    // Register reset values.
    localparam logic [CFG_W-1:0]    GAIN_OFFSET_RST = 64'h1000_0000_0000_0000;
    localparam logic [CFG_W-1:0]    LINKS_RST       = 64'd37534689871092122;
    localparam logic [ORIGIN_W-1:0] ORIGIN_RST      = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_JOINT1,
        REG_JOINT2,
        REG_JOINT3,
        REG_GIMBAL1,
        REG_GIMBAL2,
        REG_GIMBAL3,
        REG_LINKS,
        REG_ORIGIN
    } reg_idx_t;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    typedef struct packed {
        quad_t                     quad;
        logic signed [TRIG_W-1:0]  t;
        logic signed [TRIG_W-1:0]  x2;
        logic signed [TRIG_W-1:0]  tx2;
        logic signed [TRIG_W-1:0]  ps;
        logic signed [TRIG_W-1:0]  pc;
    } poly_t;

    // Q.30 product with floor: bits above the 30 dropped fraction bits.
    function automatic logic signed [MQ_W-1:0] mq(input logic signed [MQ_W-1:0] a,
                                                  input logic signed [TRIG_W-1:0] b);
        logic signed [MQ_W+TRIG_W-1:0] prod;
        prod = a * b;
        return prod[MQ_W+29:30];
    endfunction

    function automatic logic signed [TRIG_W-1:0] mq32(input logic signed [TRIG_W-1:0] a,
                                                      input logic signed [TRIG_W-1:0] b);
        return TRIG_W'(mq(MQ_W'(a), b));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hafk_reduce_cell.sv =====
`default_nettype none
// ============================================================================
// hafk_reduce_cell: one step of the modulo two-pi reduction
// Subtracts a fixed multiple of two pi when the value is at least that large.
// ============================================================================
module hafk_reduce_cell #(
    parameter int SHIFT = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [hafk_pkg::RED_W-1:0] in_x,
    output logic                       out_valid,
    output logic [hafk_pkg::RED_W-1:0] out_x
);
    import hafk_pkg::*;

    localparam logic [RED_W-1:0] STEP = RED_W'(TWO_PI) << SHIFT;

    logic             vld_reg;
    logic [RED_W-1:0] x_reg;
    logic [RED_W-1:0] x_next;

    always_comb
    begin
        x_next = (in_x >= STEP) ? in_x - STEP : in_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign out_valid = vld_reg;
    assign out_x     = x_reg;

endmodule
`default_nettype wire

// ===== rtl/hafk_poly_cell.sv =====
`default_nettype none
// ============================================================================
// hafk_poly_cell: one Horner step of the sine and cosine polynomials
// Every cell steps the cosine, cells 0-3 the sine too, and hands the record on.
// ============================================================================
module hafk_poly_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  hafk_pkg::poly_t in_st,
    output logic            out_valid,
    output hafk_pkg::poly_t out_st
);
    import hafk_pkg::*;

    localparam logic signed [TRIG_W-1:0] SIN_ADD =
        (IDX < SIN_CELLS) ? SIN_K[IDX % SIN_CELLS] : '0;
    localparam logic signed [TRIG_W-1:0] COS_ADD = COS_K[IDX];

    logic  vld_reg;
    poly_t st_reg;
    poly_t st_next;

    always_comb
    begin
        st_next    = in_st;
        st_next.pc = mq32($signed(in_st.pc), $signed(in_st.x2)) + COS_ADD;
        if (IDX == 0)
        begin
            st_next.tx2 = mq32($signed(in_st.t), $signed(in_st.x2));
        end
        if (IDX < SIN_CELLS)
        begin
            st_next.ps = mq32($signed(in_st.ps), $signed(in_st.x2)) + SIN_ADD;
        end
        else if (IDX == SIN_CELLS)
        begin
            // Closing sine step: t + t*x2*p.
            st_next.ps = mq32($signed(in_st.tx2), $signed(in_st.ps)) + $signed(in_st.t);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign out_valid = vld_reg;
    assign out_st    = st_reg;

endmodule
`default_nettype wire

// ===== rtl/hafk_sincos.sv =====
`default_nettype none
// ============================================================================
// hafk_sincos: angle correction, reduction and sine/cosine
// Gain and offset correction, a chain of reduction cells, octant folding and
// a chain of polynomial cells, followed by the quadrant mapping.
// ============================================================================
module hafk_sincos (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [hafk_pkg::ANGLE_W-1:0] angle,
    input  logic [hafk_pkg::CFG_W-1:0]          gain_offset,
    output logic                                out_valid,
    output logic signed [hafk_pkg::TRIG_W-1:0]  sin_out,
    output logic signed [hafk_pkg::TRIG_W-1:0]  cos_out
);
    import hafk_pkg::*;

    localparam logic [31:0] H1 = 32'(HALF_PI);
    localparam logic [31:0] H2 = 32'(HALF_PI) * 32'd2;
    localparam logic [31:0] H3 = 32'(HALF_PI) * 32'd3;
    localparam logic [31:0] H4 = 32'(HALF_PI) * 32'd4;
    localparam logic signed [TRIG_W-1:0] T_LIM = $signed(H2);
    localparam logic signed [TRIG_W-1:0] TRIG_LIM = 32'sd1074790400;

    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     bias_vld_reg;
    logic [RED_W-1:0]         bias_reg;
    logic [RED_W-1:0]         bias_next;
    logic signed [RED_W-1:0]  v_sum;

    logic                     red_vld [RED_STEPS+1];
    logic [RED_W-1:0]         red_x   [RED_STEPS+1];

    logic [TWO_PI_W-1:0]      r_val;
    logic [31:0]              r_e;
    logic [2:0]               q_val;
    logic [31:0]              q_h;
    logic signed [32:0]       u_val;
    logic                     fold_vld_reg;
    logic signed [TRIG_W-1:0] t_reg;
    logic signed [TRIG_W-1:0] t_next;
    quad_t                    quad_reg;
    quad_t                    quad_next;

    logic                     x2_vld_reg;
    poly_t                    x2_reg;
    poly_t                    x2_next;

    logic                     poly_vld [POLY_CELLS+1];
    poly_t                    poly_st  [POLY_CELLS+1];

    logic                     map_vld_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;
    poly_t                    last_st;

    // Correction: gain * angle, then drop 20 fraction bits and add the offset.
    always_comb
    begin
        prod_next = $signed(gain_offset[63:32]) * angle;
        v_sum     = RED_W'($signed(prod_reg[PROD_W-1:20])) + RED_W'($signed(gain_offset[31:0]));
        bias_next = RED_W'($unsigned(v_sum) + RED_BIAS);
    end

    assign red_vld[0] = bias_vld_reg;
    assign red_x[0]   = bias_reg;

    for (genvar k = 0; k < RED_STEPS; k++)
    begin : g_red
        hafk_reduce_cell #(
            .SHIFT(RED_STEPS - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (red_vld[k]),
            .in_x     (red_x[k]),
            .out_valid(red_vld[k+1]),
            .out_x    (red_x[k+1])
        );
    end

    // Fold into an octant around a multiple of pi/2.
    always_comb
    begin
        r_val     = red_x[RED_STEPS][TWO_PI_W-1:0];
        r_e       = 32'(r_val) + 32'(EIGHTH_TURN);
        q_val     = 3'(r_e >= H1) + 3'(r_e >= H2) + 3'(r_e >= H3) + 3'(r_e >= H4);
        q_h       = 32'(q_val) * H1;
        u_val     = $signed({2'b00, r_val}) - $signed({1'b0, q_h});
        t_next    = $signed({u_val[29:0], 2'b00});
        quad_next = quad_t'(q_val[1:0]);
    end

    always_comb
    begin
        x2_next.quad = quad_reg;
        x2_next.t    = t_reg;
        x2_next.x2   = mq32(t_reg, t_reg);
        x2_next.tx2  = '0;
        x2_next.ps   = SIN_INIT;
        x2_next.pc   = COS_INIT;
    end

    assign poly_vld[0] = x2_vld_reg;
    assign poly_st[0]  = x2_reg;

    for (genvar k = 0; k < POLY_CELLS; k++)
    begin : g_poly
        hafk_poly_cell #(
            .IDX(k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (poly_vld[k]),
            .in_st    (poly_st[k]),
            .out_valid(poly_vld[k+1]),
            .out_st   (poly_st[k+1])
        );
    end

    always_comb
    begin
        last_st = poly_st[POLY_CELLS];
        case (last_st.quad)
            QUAD_I:
            begin
                sin_next = $signed(last_st.ps);
                cos_next = $signed(last_st.pc);
            end
            QUAD_II:
            begin
                sin_next = $signed(last_st.pc);
                cos_next = -$signed(last_st.ps);
            end
            QUAD_III:
            begin
                sin_next = -$signed(last_st.ps);
                cos_next = -$signed(last_st.pc);
            end
            default:
            begin
                sin_next = -$signed(last_st.pc);
                cos_next = $signed(last_st.ps);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            bias_vld_reg <= 1'b0;
            fold_vld_reg <= 1'b0;
            x2_vld_reg   <= 1'b0;
            map_vld_reg  <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= in_valid;
            bias_vld_reg <= prod_vld_reg;
            fold_vld_reg <= red_vld[RED_STEPS];
            x2_vld_reg   <= fold_vld_reg;
            map_vld_reg  <= poly_vld[POLY_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        bias_reg <= bias_next;
        t_reg    <= t_next;
        quad_reg <= quad_next;
        x2_reg   <= x2_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    assign out_valid = map_vld_reg;
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        red_vld[RED_STEPS] |-> (red_x[RED_STEPS] < RED_W'(TWO_PI)))
        else $error("reduced angle is not below two pi");

    a_folded: assert property (@(posedge clk) disable iff (!rst_n)
        fold_vld_reg |-> (t_reg >= -T_LIM && t_reg < T_LIM))
        else $error("folded angle is outside one octant");

    a_trig: assert property (@(posedge clk) disable iff (!rst_n)
        map_vld_reg |-> (sin_reg <= TRIG_LIM && sin_reg >= -TRIG_LIM
                         && cos_reg <= TRIG_LIM && cos_reg >= -TRIG_LIM))
        else $error("sine or cosine out of range");

endmodule
`default_nettype wire

// ===== rtl/hafk_pose.sv =====
`default_nettype none
// ============================================================================
// hafk_pose: rotation matrix and stylus position from the six sine/cosine pairs
// Five stages: pair products, triple products and link terms, partial sums,
// final matrix entries, rounding and saturation into the output registers.
// ============================================================================
module hafk_pose (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [hafk_pkg::TRIG_W-1:0] sn [hafk_pkg::NUM_ANGLES],
    input  logic signed [hafk_pkg::TRIG_W-1:0] cs [hafk_pkg::NUM_ANGLES],
    input  logic [hafk_pkg::CFG_W-1:0]         link_lengths,
    input  logic [hafk_pkg::ORIGIN_W-1:0]      origin_offset,
    output logic                               out_valid,
    output logic signed [hafk_pkg::ROT_W-1:0]  rot [hafk_pkg::NUM_ROT],
    output logic signed [hafk_pkg::POS_W-1:0]  pos [hafk_pkg::NUM_POS]
);
    import hafk_pkg::*;

    localparam int EW = MQ_W + 1;
    localparam int LW = 51;
    localparam int SW = 56;

    function automatic logic signed [LW-1:0] lterm(input logic [31:0] len,
                                                   input logic signed [TRIG_W-1:0] t);
        logic signed [64:0] prod;
        prod = $signed({1'b0, len}) * t;
        return prod[64:14];
    endfunction

    function automatic logic signed [ROT_W-1:0] rot_sat(input logic signed [EW-1:0] v);
        logic signed [EW:0]   s;
        logic signed [EW-14:0] r;
        s = (EW+1)'(v) + (EW+1)'(8192);
        r = s[EW:14];
        if (r > (EW-13)'(131071))
            return 18'sd131071;
        else if (r < -(EW-13)'(131072))
            return -18'sd131072;
        return r[ROT_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] pos_sat(input logic signed [SW-1:0] v);
        logic signed [SW:0]    s;
        logic signed [SW-16:0] r;
        s = (SW+1)'(v) + (SW+1)'(32768);
        r = s[SW:16];
        if (r > (SW-15)'(64'sd2147483647))
            return 32'sh7FFF_FFFF;
        else if (r < -(SW-15)'(64'sd2147483648))
            return 32'sh8000_0000;
        return r[POS_W-1:0];
    endfunction

    logic [4:0] vld_reg;

    // Stage 1: pair products.
    logic signed [TRIG_W-1:0] s1c3_reg, s4c1_reg, s1s3_reg, s1s4_reg, c1c4_reg;
    logic signed [TRIG_W-1:0] s3s5_reg, c3c5_reg, c1c3_reg, s3c1_reg, s1c4_reg;
    logic signed [TRIG_W-1:0] s3s4_reg, s3c4_reg, c2s1_reg, c2c1_reg;
    logic signed [TRIG_W-1:0] sn1_reg [NUM_ANGLES];
    logic signed [TRIG_W-1:0] cs1_reg [NUM_ANGLES];

    // Stage 2: triple products and link terms.
    logic signed [MQ_W-1:0]   a_reg, q_reg, r_reg, d_reg, v_reg;
    logic signed [MQ_W-1:0]   s1s3c5_reg, s3c1c5_reg, s1s3s5_reg;
    logic signed [MQ_W-1:0]   s3s4c6_reg, s3s4s6_reg, s3c4c5_reg, s3s5c1_reg, s5c3_reg;
    logic signed [LW-1:0]     lt_reg [6];
    logic signed [TRIG_W-1:0] sn2_reg [NUM_ANGLES];
    logic signed [TRIG_W-1:0] cs2_reg [NUM_ANGLES];

    // Stage 3: partial sums.
    logic signed [MQ_W-1:0]   p3_reg, u3_reg, q3_reg, r3_reg, v3_reg;
    logic signed [MQ_W-1:0]   s3s4c6_3_reg, s3s4s6_3_reg;
    logic signed [EW-1:0]     e3_reg [3];
    logic signed [SW-1:0]     ps3_reg [NUM_POS];
    logic signed [TRIG_W-1:0] sn3_reg [NUM_ANGLES];
    logic signed [TRIG_W-1:0] cs3_reg [NUM_ANGLES];

    // Stage 4: matrix entries.
    logic signed [EW-1:0]     e4_reg [NUM_ROT];
    logic signed [SW-1:0]     ps4_reg [NUM_POS];

    // Stage 5: output registers.
    logic signed [ROT_W-1:0]  rot_reg [NUM_ROT];
    logic signed [POS_W-1:0]  pos_reg [NUM_POS];

    logic [31:0]          l1;
    logic [31:0]          l2;
    logic signed [SW-1:0] ox, oy, oz;

    always_comb
    begin
        l1 = link_lengths[63:32];
        l2 = link_lengths[31:0];
        ox = SW'($signed(origin_offset[20:0])) <<< 22;
        oy = SW'($signed(origin_offset[41:21])) <<< 22;
        oz = SW'($signed(origin_offset[62:42])) <<< 22;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1
        s1c3_reg <= mq32(sn[0], cs[2]);
        s4c1_reg <= mq32(sn[3], cs[0]);
        s1s3_reg <= mq32(sn[0], sn[2]);
        s1s4_reg <= mq32(sn[0], sn[3]);
        c1c4_reg <= mq32(cs[0], cs[3]);
        s3s5_reg <= mq32(sn[2], sn[4]);
        c3c5_reg <= mq32(cs[2], cs[4]);
        c1c3_reg <= mq32(cs[0], cs[2]);
        s3c1_reg <= mq32(sn[2], cs[0]);
        s1c4_reg <= mq32(sn[0], cs[3]);
        s3s4_reg <= mq32(sn[2], sn[3]);
        s3c4_reg <= mq32(sn[2], cs[3]);
        c2s1_reg <= mq32(cs[1], sn[0]);
        c2c1_reg <= mq32(cs[1], cs[0]);
        sn1_reg  <= sn;
        cs1_reg  <= cs;

        // Stage 2
        a_reg      <= mq(MQ_W'(s1c3_reg), cs1_reg[3]) - MQ_W'(s4c1_reg);
        q_reg      <= mq(MQ_W'(s1s4_reg), cs1_reg[2]) + MQ_W'(c1c4_reg);
        r_reg      <= mq(MQ_W'(s3s5_reg), cs1_reg[3]) - MQ_W'(c3c5_reg);
        d_reg      <= MQ_W'(s1s4_reg) + mq(MQ_W'(c1c3_reg), cs1_reg[3]);
        v_reg      <= MQ_W'(s1c4_reg) - mq(MQ_W'(s4c1_reg), cs1_reg[2]);
        s1s3c5_reg <= mq(MQ_W'(s1s3_reg), cs1_reg[4]);
        s3c1c5_reg <= mq(MQ_W'(s3c1_reg), cs1_reg[4]);
        s1s3s5_reg <= mq(MQ_W'(s1s3_reg), sn1_reg[4]);
        s3s4c6_reg <= mq(MQ_W'(s3s4_reg), cs1_reg[5]);
        s3s4s6_reg <= mq(MQ_W'(s3s4_reg), sn1_reg[5]);
        s3c4c5_reg <= mq(MQ_W'(s3c4_reg), cs1_reg[4]);
        s3s5c1_reg <= mq(MQ_W'(s3s5_reg), cs1_reg[0]);
        s5c3_reg   <= MQ_W'(mq32(sn1_reg[4], cs1_reg[2]));
        lt_reg[0]  <= lterm(l1, c2s1_reg);
        lt_reg[1]  <= lterm(l2, s1s3_reg);
        lt_reg[2]  <= lterm(l1, sn1_reg[1]);
        lt_reg[3]  <= lterm(l2, cs1_reg[2]);
        lt_reg[4]  <= lterm(l1, c2c1_reg);
        lt_reg[5]  <= lterm(l2, s3c1_reg);
        sn2_reg    <= sn1_reg;
        cs2_reg    <= cs1_reg;

        // Stage 3
        p3_reg       <= mq(a_reg, sn2_reg[4]) + s1s3c5_reg;
        u3_reg       <= mq(d_reg, sn2_reg[4]) + s3c1c5_reg;
        e3_reg[0]    <= EW'(s1s3s5_reg) - EW'(mq(a_reg, cs2_reg[4]));
        e3_reg[1]    <= EW'(s3c4c5_reg) + EW'(s5c3_reg);
        e3_reg[2]    <= EW'(mq(d_reg, cs2_reg[4])) - EW'(s3s5c1_reg);
        q3_reg       <= q_reg;
        r3_reg       <= r_reg;
        v3_reg       <= v_reg;
        s3s4c6_3_reg <= s3s4c6_reg;
        s3s4s6_3_reg <= s3s4s6_reg;
        ps3_reg[0]   <= ox - SW'(lt_reg[0]) - SW'(lt_reg[1]);
        ps3_reg[1]   <= oy + SW'(lt_reg[2]) - SW'(lt_reg[3]) + $signed(SW'({l2, 16'h0000}));
        ps3_reg[2]   <= oz - $signed(SW'({l1, 16'h0000})) + SW'(lt_reg[4]) + SW'(lt_reg[5]);
        sn3_reg      <= sn2_reg;
        cs3_reg      <= cs2_reg;

        // Stage 4
        e4_reg[0] <= EW'(mq(q3_reg, cs3_reg[5])) - EW'(mq(p3_reg, sn3_reg[5]));
        e4_reg[1] <= EW'(mq(p3_reg, cs3_reg[5])) + EW'(mq(q3_reg, sn3_reg[5]));
        e4_reg[2] <= e3_reg[0];
        e4_reg[3] <= EW'(mq(r3_reg, sn3_reg[5])) - EW'(s3s4c6_3_reg);
        e4_reg[4] <= -EW'(mq(r3_reg, cs3_reg[5])) - EW'(s3s4s6_3_reg);
        e4_reg[5] <= e3_reg[1];
        e4_reg[6] <= EW'(mq(u3_reg, sn3_reg[5])) + EW'(mq(v3_reg, cs3_reg[5]));
        e4_reg[7] <= EW'(mq(v3_reg, sn3_reg[5])) - EW'(mq(u3_reg, cs3_reg[5]));
        e4_reg[8] <= e3_reg[2];
        ps4_reg   <= ps3_reg;

        // Stage 5
        for (int i = 0; i < NUM_ROT; i++)
        begin
            rot_reg[i] <= rot_sat(e4_reg[i]);
        end
        for (int i = 0; i < NUM_POS; i++)
        begin
            pos_reg[i] <= pos_sat(ps4_reg[i]);
        end
    end

    assign out_valid = vld_reg[4];
    assign rot       = rot_reg;
    assign pos       = pos_reg;

endmodule
`default_nettype wire

// ===== rtl/haptic_arm_forward_kinematics.sv =====
`default_nettype none
// ============================================================================
// haptic_arm_forward_kinematics: stylus pose of a six-angle haptic arm
// Corrects six raw angles, takes their sines and cosines and forms the
// stylus rotation matrix and the saturated stylus position.
// ============================================================================
// Usage:
// An item (three joint angles and three gimbal angles, Q4.20 radians) is
// taken at a rising edge with start high; busy is always low, because the
// datapath is a fully pipelined row of cells and a new item may enter in
// every cycle. One item per cycle is the sustained rate.
// The result item (nine Q2.16 matrix entries and three Q16.16 positions)
// is held for one cycle and marked by done. It goes through the per-angle cell
// chain (multiply, offset, seven reduction cells, octant fold, square, five
// polynomial cells, quadrant map) and then the pose stages.
// The receiver cannot stall; results are never held back.
// Configuration is a plain write port: cfg_we, cfg_index and cfg_wdata.
// Writes to indexes beyond the register list are dropped. Registers are read
// live; the user must change them only when no item is in flight (unenforced).
// Reset clears the pipeline valid bits and restores the register defaults:
// unit gains, zero offsets, both links 133.35 mm and a zero origin.
// ============================================================================
module haptic_arm_forward_kinematics (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hafk_pkg::ANGLE_W-1:0]   joint_angle_1,
    input  logic signed [hafk_pkg::ANGLE_W-1:0]   joint_angle_2,
    input  logic signed [hafk_pkg::ANGLE_W-1:0]   joint_angle_3,
    input  logic signed [hafk_pkg::ANGLE_W-1:0]   gimbal_angle_1,
    input  logic signed [hafk_pkg::ANGLE_W-1:0]   gimbal_angle_2,
    input  logic signed [hafk_pkg::ANGLE_W-1:0]   gimbal_angle_3,
    input  logic                                  cfg_we,
    input  logic [hafk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hafk_pkg::CFG_W-1:0]            cfg_wdata,
    output logic                                  done,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_00,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_01,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_02,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_10,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_11,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_12,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_20,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_21,
    output logic signed [hafk_pkg::ROT_W-1:0]     rot_22,
    output logic signed [hafk_pkg::POS_W-1:0]     pos_x,
    output logic signed [hafk_pkg::POS_W-1:0]     pos_y,
    output logic signed [hafk_pkg::POS_W-1:0]     pos_z
);
    import hafk_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]    gain_offset_reg [NUM_ANGLES];
    logic [CFG_W-1:0]    link_lengths_reg;
    logic [ORIGIN_W-1:0] origin_offset_reg;

    logic                     accept;
    logic signed [ANGLE_W-1:0] angle_in [NUM_ANGLES];
    logic                     sc_vld   [NUM_ANGLES];
    logic signed [TRIG_W-1:0] sn       [NUM_ANGLES];
    logic signed [TRIG_W-1:0] cs       [NUM_ANGLES];
    logic signed [ROT_W-1:0]  rot      [NUM_ROT];
    logic signed [POS_W-1:0]  pos      [NUM_POS];

    // The pipeline never refuses an item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ANGLES; i++)
            begin
                gain_offset_reg[i] <= GAIN_OFFSET_RST;
            end
            link_lengths_reg  <= LINKS_RST;
            origin_offset_reg <= ORIGIN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index inside {[REG_JOINT1:REG_GIMBAL3]})
            begin
                gain_offset_reg[cfg_index[2:0]] <= cfg_wdata;
            end
            else if (cfg_index == REG_LINKS)
            begin
                link_lengths_reg <= cfg_wdata;
            end
            else if (cfg_index == REG_ORIGIN)
            begin
                // The top bit of the data word has no place in this register.
                origin_offset_reg <= cfg_wdata[ORIGIN_W-1:0];
            end
        end
    end

    assign angle_in[0] = joint_angle_1;
    assign angle_in[1] = joint_angle_2;
    assign angle_in[2] = joint_angle_3;
    assign angle_in[3] = gimbal_angle_1;
    assign angle_in[4] = gimbal_angle_2;
    assign angle_in[5] = gimbal_angle_3;

    // One sine/cosine chain per angle; all six run in lockstep.
    for (genvar k = 0; k < NUM_ANGLES; k++)
    begin : g_angle
        hafk_sincos u_sincos (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (accept),
            .angle      (angle_in[k]),
            .gain_offset(gain_offset_reg[k]),
            .out_valid  (sc_vld[k]),
            .sin_out    (sn[k]),
            .cos_out    (cs[k])
        );
    end

    hafk_pose u_pose (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sc_vld[0]),
        .sn           (sn),
        .cs           (cs),
        .link_lengths (link_lengths_reg),
        .origin_offset(origin_offset_reg),
        .out_valid    (done),
        .rot          (rot),
        .pos          (pos)
    );

    assign rot_00 = rot[0];
    assign rot_01 = rot[1];
    assign rot_02 = rot[2];
    assign rot_10 = rot[3];
    assign rot_11 = rot[4];
    assign rot_12 = rot[5];
    assign rot_20 = rot[6];
    assign rot_21 = rot[7];
    assign rot_22 = rot[8];
    assign pos_x  = pos[0];
    assign pos_y  = pos[1];
    assign pos_z  = pos[2];

endmodule
`default_nettype wire
